// ----- hw/rtl/mmx_pkg.sv -----
// Package for the Montgomery modular exponentiation unit.
// Holds the shared widths, the sequencer and datapath codes and the datapath control struct.
// No dependencies.
package mmx_pkg;

    localparam int unsigned WordBits = 32;
    localparam int unsigned AccBits  = WordBits + 2;   // product accumulator, holds < 2n
    localparam int unsigned CntBits  = 6;              // step counter, 64 steps max
    localparam int unsigned BitIdx   = 5;              // exponent bit index

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_PROD,
        S_FIX,
        S_OUT
    } t_state;

    // what the shared datapath is currently working on
    typedef enum logic [2:0] {
        K_CVB,   // base into Montgomery form
        K_CVO,   // constant one into Montgomery form
        K_SQR,
        K_MUL,
        K_FIN    // leave Montgomery form
    } t_kind;

    typedef enum logic [1:0] {
        ALU_HOLD,
        ALU_DBL,    // t = 2t + bit, reduced mod n
        ALU_STEP    // one radix-2 Montgomery step
    } t_alu_op;

    typedef struct packed {
        t_alu_op op;
        logic    clr;   // treat accumulator as zero this step
        logic    bit_in;
    } t_alu_ctl;

endpackage

// ----- hw/rtl/mmx_if.sv -----
// Valid/ready channel interfaces for the exponentiation unit.
// Depends on nothing; payload widths are the fixed field widths.
interface mmx_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] base_value;
    logic [31:0] exponent_value;
    logic [31:0] modulus_value;

    modport source (output valid, base_value, exponent_value, modulus_value, input ready);
    modport sink   (input valid, base_value, exponent_value, modulus_value, output ready);
endinterface

interface mmx_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] power_result;
    logic        bad_modulus;

    modport source (output valid, power_result, bad_modulus, input ready);
    modport sink   (input valid, power_result, bad_modulus, output ready);
endinterface

// ----- hw/rtl/montgomery_modular_exponentiation_unit.sv -----
// Top level of the Montgomery modular exponentiation unit: computes a^e mod n.
// Depends on mmx_pkg, mmx_if (mmx_in_if, mmx_out_if) and mmx_alu.
//
// Usage:
//   i_in carries one transaction per job: base_value, exponent_value and an odd
//   modulus_value. o_out returns power_result = base^exponent mod modulus and
//   bad_modulus. An even or zero modulus gives power_result 0, bad_modulus 1.
// Sequence:
//   One job at a time. i_in.ready is high only while the sequencer is idle.
//   A good job first converts the base and then one into Montgomery form by
//   doubling steps, each run followed by a fixup state; then it squares for
//   all 32 exponent bits, multiplies once more per set exponent bit and ends
//   with the exit product. o_out.valid and i_in.ready rise in the same cycle.
//   All of it runs through the single bit-serial add/shift unit in mmx_alu,
//   one multiplier bit per cycle. A bad modulus goes from idle straight to
//   the output state.
// Reset / stall:
//   i_rst_n (synchronous, active low) returns the sequencer to idle and drops
//   o_out.valid. The result sits in an output register; while the receiver
//   stalls, the next job can be accepted and run, and it waits in its final
//   state only if the output register is still full at its end.
module montgomery_modular_exponentiation_unit
    import mmx_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    mmx_in_if.sink    i_in,
    mmx_out_if.source o_out
);

    t_state              r_state, n_state;
    t_kind               r_kind;
    logic [CntBits-1:0]  r_cnt;
    logic [BitIdx-1:0]   r_bit;
    logic [WordBits-1:0] r_n, r_e, r_x, r_base, r_pow, r_res;
    logic                r_bad, r_ob, r_ov;

    t_alu_ctl            alu_ctl;
    logic [WordBits-1:0] alu_y;
    logic [WordBits-1:0] red;

    logic in_fire, in_bad, out_free;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign in_bad     = ~i_in.modulus_value[0];   // even, zero included
    assign out_free   = !r_ov || o_out.ready;

    // Shared datapath
    mmx_alu u_alu (
        .i_clk (i_clk),
        .i_ctl (alu_ctl),
        .i_y   (alu_y),
        .i_n   (r_n),
        .o_red (red)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_fire) n_state = in_bad ? S_OUT : S_CONV;
            S_CONV: if (r_cnt == '1) n_state = S_FIX;
            S_PROD: if (r_cnt == CntBits'(WordBits - 1)) n_state = S_FIX;
            S_FIX: begin
                if (r_kind == K_CVB)      n_state = S_CONV;
                else if (r_kind == K_FIN) n_state = S_OUT;
                else                      n_state = S_PROD;
            end
            S_OUT: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath control
    always_comb begin
        alu_ctl.op     = ALU_HOLD;
        alu_ctl.clr    = (r_cnt == '0);
        alu_ctl.bit_in = 1'b0;
        unique case (r_state)
            S_CONV: begin
                // first half of the steps shifts the operand in, second half only doubles
                alu_ctl.op     = ALU_DBL;
                alu_ctl.bit_in = r_x[WordBits-1] && !r_cnt[CntBits-1];
            end
            S_PROD: begin
                alu_ctl.op     = ALU_STEP;
                alu_ctl.bit_in = r_x[0];
            end
            default: alu_ctl.op = ALU_HOLD;
        endcase
    end

    always_comb begin
        case (r_kind)
            K_MUL:   alu_y = r_base;
            K_FIN:   alu_y = WordBits'(1);
            default: alu_y = r_pow;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= K_CVB;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_kind <= K_CVB;
                        r_cnt  <= '0;
                    end
                end
                S_CONV, S_PROD: r_cnt <= r_cnt + 1'b1;
                S_FIX: begin
                    r_cnt <= '0;
                    case (r_kind)
                        K_CVB: r_kind <= K_CVO;
                        K_CVO: r_kind <= K_SQR;
                        K_SQR: begin
                            if (r_e[r_bit])        r_kind <= K_MUL;
                            else if (r_bit == '0)  r_kind <= K_FIN;
                            else                   r_kind <= K_SQR;
                        end
                        K_MUL: r_kind <= (r_bit == '0) ? K_FIN : K_SQR;
                        default: r_kind <= r_kind;
                    endcase
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Operand registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_n   <= i_in.modulus_value;
                    r_e   <= i_in.exponent_value;
                    r_x   <= i_in.base_value;
                    r_bad <= in_bad;
                    r_pow <= '0;
                end
            end
            S_CONV: r_x <= {r_x[WordBits-2:0], 1'b0};
            S_PROD: r_x <= {1'b0, r_x[WordBits-1:1]};
            S_FIX: begin
                case (r_kind)
                    K_CVB: begin
                        r_base <= red;
                        r_x    <= WordBits'(1);
                    end
                    K_CVO: begin
                        r_pow <= red;
                        r_x   <= red;
                        r_bit <= '1;
                    end
                    K_SQR: begin
                        r_pow <= red;
                        r_x   <= red;
                        if (!r_e[r_bit] && r_bit != '0) r_bit <= r_bit - 1'b1;
                    end
                    K_MUL: begin
                        r_pow <= red;
                        r_x   <= red;
                        if (r_bit != '0) r_bit <= r_bit - 1'b1;
                    end
                    default: r_pow <= red;
                endcase
            end
            default: r_x <= r_x;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_res <= r_pow;
            r_ob  <= r_bad;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.power_result = r_res;
    assign o_out.bad_modulus  = r_ob;

    // Assertions
    a_bad_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && in_bad |=> r_state == S_OUT)
        else $error("bad modulus did not go straight to output");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.bad_modulus |-> o_out.power_result == '0)
        else $error("bad modulus with nonzero result");

    a_pow_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PROD |-> r_pow < r_n && r_base < r_n)
        else $error("Montgomery operand not reduced");

    a_out_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && !out_free |=> r_state == S_OUT)
        else $error("result dropped while output full");

endmodule

// ----- hw/rtl/mmx_alu.sv -----
// Shared arithmetic unit: modular doubling and radix-2 Montgomery steps.
// Depends on mmx_pkg.
module mmx_alu
    import mmx_pkg::*;
(
    input  logic                i_clk,
    input  t_alu_ctl            i_ctl,
    input  logic [WordBits-1:0] i_y,
    input  logic [WordBits-1:0] i_n,
    output logic [WordBits-1:0] o_red
);

    logic [AccBits-1:0] r_t;
    logic [AccBits-1:0] n_t;
    logic [AccBits-1:0] t0;
    logic [AccBits-1:0] dbl;
    logic [AccBits:0]   s1;
    logic [AccBits:0]   s2;
    logic [AccBits-1:0] n_ext;

    assign n_ext = {2'b00, i_n};
    assign t0    = i_ctl.clr ? '0 : r_t;
    assign dbl   = {t0[AccBits-2:0], i_ctl.bit_in};
    assign s1    = {1'b0, t0} + (i_ctl.bit_in ? {3'b000, i_y} : '0);
    assign s2    = s1 + (s1[0] ? {1'b0, n_ext} : '0);

    always_comb begin
        case (i_ctl.op)
            ALU_DBL:  n_t = (dbl >= n_ext) ? dbl - n_ext : dbl;
            ALU_STEP: n_t = s2[AccBits:1];
            default:  n_t = r_t;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_t <= n_t;
    end

    // final conditional subtraction, t < 2n here
    logic [AccBits-1:0] red_full;
    assign red_full = (r_t >= n_ext) ? r_t - n_ext : r_t;
    assign o_red    = red_full[WordBits-1:0];

endmodule
